// File: rtl/cpe_pkg.sv
package cpe_pkg;

  // Coordinate and parameter formats.
  localparam int COORD_WIDTH     = 16;
  localparam int PARAM_FRAC_BITS = 16;

  // Parameter t carries one integer bit so that exactly 1.0 is representable.
  localparam int T_W       = PARAM_FRAC_BITS + 1;
  localparam int PARAM_ONE = 1 << PARAM_FRAC_BITS;
  localparam int RND_HALF  = 1 << (PARAM_FRAC_BITS - 1);

  // Lerp datapath widths.
  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int PROD1_W = DIFF_W + T_W + 1;
  localparam int MID_W   = COORD_WIDTH + 1;
  localparam int DM_W    = MID_W + 1;
  localparam int PROD2_W = DM_W + T_W + 1;

  // Hermite datapath widths.
  localparam int TT_W = 2 * T_W;
  localparam int H_W  = PARAM_FRAC_BITS + 4;
  localparam int HP_W = H_W + COORD_WIDTH;
  localparam int HS_W = HP_W + 2;
  localparam int V_W  = HS_W;

  // Pipeline: stage 0 holds the input item, stage 5 the Hermite weights,
  // stage 9 the saturated lane results and stage 10 the output register.
  localparam int PIPE_DEPTH = 11;
  localparam int STG_IN     = 0;
  localparam int STG_WTS    = 5;
  localparam int STG_LANE   = 9;
  localparam int STG_OUT    = 10;

  typedef enum logic [1:0] {
    OP_LERP    = 2'd0,
    OP_BEZIER  = 2'd1,
    OP_HERMITE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef logic [PIPE_DEPTH-1:0]       stage_en_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [T_W-1:0]              param_t;
  typedef logic signed [H_W-1:0]       weight_t;

  typedef struct packed {
    weight_t h00;
    weight_t h10;
    weight_t h01;
    weight_t h11;
  } herm_wts_t;

  typedef struct packed {
    coord_t value;
    logic   clip;
  } lane_res_t;

endpackage

// File: rtl/cpe_in_if.sv
interface cpe_in_if;
  import cpe_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  coord_t     pa_x;
  coord_t     pa_y;
  coord_t     pb_x;
  coord_t     pb_y;
  coord_t     pc_x;
  coord_t     pc_y;
  coord_t     pd_x;
  coord_t     pd_y;
  param_t     curve_param;

  modport source (
    output valid, opcode, pa_x, pa_y, pb_x, pb_y, pc_x, pc_y, pd_x, pd_y, curve_param,
    input  ready
  );

  modport sink (
    input  valid, opcode, pa_x, pa_y, pb_x, pb_y, pc_x, pc_y, pd_x, pd_y, curve_param,
    output ready
  );

endinterface

// File: rtl/cpe_out_if.sv
interface cpe_out_if;
  import cpe_pkg::*;

  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  logic   saturated;

  modport source (
    output valid, out_x, out_y, saturated,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, saturated,
    output ready
  );

endinterface

// File: rtl/cpe_basis.sv
module cpe_basis (
  input  logic               clk,
  input  cpe_pkg::stage_en_t en,
  input  cpe_pkg::param_t    t,
  output cpe_pkg::herm_wts_t wts
);
  import cpe_pkg::*;

  logic [TT_W-1:0] tt_r;
  logic [TT_W-1:0] tc_r;
  param_t          t_r [1:4];
  param_t          tsq_r [2:4];
  param_t          tcub_r;
  herm_wts_t       wts_r;

  logic [TT_W-1:0] tt_rnd;
  logic [TT_W-1:0] tc_rnd;
  weight_t         c_s;
  weight_t         s_s;
  weight_t         t_s;
  weight_t         one_s;
  herm_wts_t       wts_nxt;

  // Round to nearest by adding a half and dropping the fraction bits.
  assign tt_rnd = tt_r + TT_W'(RND_HALF);
  assign tc_rnd = tc_r + TT_W'(RND_HALF);

  always_comb begin
    c_s   = $signed(H_W'(tcub_r));
    s_s   = $signed(H_W'(tsq_r[4]));
    t_s   = $signed(H_W'(t_r[4]));
    one_s = H_W'(PARAM_ONE);
    wts_nxt.h00 = c_s + c_s - s_s - s_s - s_s + one_s;
    wts_nxt.h01 = s_s + s_s + s_s - c_s - c_s;
    wts_nxt.h10 = c_s - s_s - s_s + t_s;
    wts_nxt.h11 = c_s - s_s;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      tt_r   <= TT_W'(t) * TT_W'(t);
      t_r[1] <= t;
    end
    if (en[2]) begin
      tsq_r[2] <= tt_rnd[PARAM_FRAC_BITS+T_W-1:PARAM_FRAC_BITS];
      t_r[2]   <= t_r[1];
    end
    if (en[3]) begin
      tc_r     <= TT_W'(tsq_r[2]) * TT_W'(t_r[2]);
      tsq_r[3] <= tsq_r[2];
      t_r[3]   <= t_r[2];
    end
    if (en[4]) begin
      tcub_r   <= tc_rnd[PARAM_FRAC_BITS+T_W-1:PARAM_FRAC_BITS];
      tsq_r[4] <= tsq_r[3];
      t_r[4]   <= t_r[3];
    end
    if (en[STG_WTS]) begin
      wts_r <= wts_nxt;
    end
  end

  assign wts = wts_r;

endmodule

// File: rtl/cpe_lane.sv
module cpe_lane (
  input  logic               clk,
  input  cpe_pkg::stage_en_t en,
  input  cpe_pkg::op_t       op,
  input  cpe_pkg::coord_t    pa,
  input  cpe_pkg::coord_t    pb,
  input  cpe_pkg::coord_t    pc,
  input  cpe_pkg::coord_t    pd,
  input  cpe_pkg::param_t    t,
  input  cpe_pkg::herm_wts_t wts,
  output cpe_pkg::lane_res_t res
);
  import cpe_pkg::*;

  localparam logic signed [V_W-1:0] SAT_MAX =
    {{(V_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [V_W-1:0] SAT_MIN =
    {{(V_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  coord_t                     pt_r [1:5][4];
  op_t                        op_r [1:7];
  param_t                     t_r [1:2];
  logic signed [PROD1_W-1:0]  d1_r;
  logic signed [PROD1_W-1:0]  d2_r;
  logic signed [MID_W-1:0]    m1_r;
  logic signed [MID_W-1:0]    m2_r;
  logic signed [MID_W-1:0]    m1_3_r;
  logic signed [PROD2_W-1:0]  e_r;
  logic signed [MID_W-1:0]    lb_r [4:7];
  logic signed [HP_W-1:0]     hp_r [4];
  logic signed [HS_W-1:0]     s01_r;
  logic signed [HS_W-1:0]     s23_r;
  logic signed [V_W-1:0]      val_r;
  coord_t                     sat_r;
  logic                       clip_r;

  logic signed [DIFF_W-1:0]   dba;
  logic signed [DIFF_W-1:0]   dcb;
  logic signed [T_W:0]        t_s1;
  logic signed [T_W:0]        t_s3;
  logic signed [PROD1_W-1:0]  q1;
  logic signed [PROD1_W-1:0]  q2;
  logic signed [DM_W-1:0]     dm;
  logic signed [PROD2_W-1:0]  qe;
  logic signed [MID_W-1:0]    bez;
  logic signed [MID_W-1:0]    lb_nxt;
  logic signed [HS_W-1:0]     herm_sum;
  logic signed [HS_W-1:0]     herm_q;
  logic signed [V_W-1:0]      val_nxt;
  coord_t                     sat_nxt;
  logic                       clip_nxt;

  // Differences and parameter in signed form for the two first-level lerps.
  assign dba  = DIFF_W'(pb) - DIFF_W'(pa);
  assign dcb  = DIFF_W'(pc) - DIFF_W'(pb);
  assign t_s1 = $signed({1'b0, t});
  assign t_s3 = $signed({1'b0, t_r[2]});

  // Rounded first-level lerp offsets.
  assign q1 = (d1_r + PROD1_W'(RND_HALF)) >>> PARAM_FRAC_BITS;
  assign q2 = (d2_r + PROD1_W'(RND_HALF)) >>> PARAM_FRAC_BITS;

  // Second-level lerp between the two midpoints.
  assign dm  = DM_W'(m2_r) - DM_W'(m1_r);
  assign qe  = (e_r + PROD2_W'(RND_HALF)) >>> PARAM_FRAC_BITS;
  assign bez = m1_3_r + MID_W'(qe);

  always_comb begin
    if (op_r[3] == OP_LERP) begin
      lb_nxt = m1_3_r;
    end else begin
      lb_nxt = bez;
    end
  end

  // Hermite sum with rounding folded into the final add.
  assign herm_sum = s01_r + s23_r + HS_W'(RND_HALF);
  assign herm_q   = herm_sum >>> PARAM_FRAC_BITS;

  always_comb begin
    unique case (op_r[7])
      OP_LERP, OP_BEZIER: val_nxt = V_W'(lb_r[7]);
      OP_HERMITE:         val_nxt = V_W'(herm_q);
      OP_NONE:            val_nxt = '0;
      default:            val_nxt = '0;
    endcase
  end

  always_comb begin
    if (val_r > SAT_MAX) begin
      sat_nxt  = COORD_WIDTH'(SAT_MAX);
      clip_nxt = 1'b1;
    end else if (val_r < SAT_MIN) begin
      sat_nxt  = COORD_WIDTH'(SAT_MIN);
      clip_nxt = 1'b1;
    end else begin
      sat_nxt  = COORD_WIDTH'(val_r);
      clip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pt_r[1][0] <= pa;
      pt_r[1][1] <= pb;
      pt_r[1][2] <= pc;
      pt_r[1][3] <= pd;
      op_r[1]    <= op;
      t_r[1]     <= t;
      d1_r       <= PROD1_W'(dba) * PROD1_W'(t_s1);
      d2_r       <= PROD1_W'(dcb) * PROD1_W'(t_s1);
    end
    for (int k = 2; k <= 5; k++) begin
      if (en[k]) begin
        pt_r[k] <= pt_r[k-1];
      end
    end
    for (int k = 2; k <= 7; k++) begin
      if (en[k]) begin
        op_r[k] <= op_r[k-1];
      end
    end
    if (en[2]) begin
      t_r[2] <= t_r[1];
      m1_r   <= MID_W'(pt_r[1][0]) + MID_W'(q1);
      m2_r   <= MID_W'(pt_r[1][1]) + MID_W'(q2);
    end
    if (en[3]) begin
      e_r    <= PROD2_W'(dm) * PROD2_W'(t_s3);
      m1_3_r <= m1_r;
    end
    if (en[4]) begin
      lb_r[4] <= lb_nxt;
    end
    for (int k = 5; k <= 7; k++) begin
      if (en[k]) begin
        lb_r[k] <= lb_r[k-1];
      end
    end
    if (en[6]) begin
      hp_r[0] <= HP_W'(wts.h00) * HP_W'(pt_r[5][0]);
      hp_r[1] <= HP_W'(wts.h10) * HP_W'(pt_r[5][1]);
      hp_r[2] <= HP_W'(wts.h01) * HP_W'(pt_r[5][2]);
      hp_r[3] <= HP_W'(wts.h11) * HP_W'(pt_r[5][3]);
    end
    if (en[7]) begin
      s01_r <= HS_W'(hp_r[0]) + HS_W'(hp_r[1]);
      s23_r <= HS_W'(hp_r[2]) + HS_W'(hp_r[3]);
    end
    if (en[8]) begin
      val_r <= val_nxt;
    end
    if (en[STG_LANE]) begin
      sat_r  <= sat_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign res.value = sat_r;
  assign res.clip  = clip_r;

endmodule

// File: rtl/curve_point_evaluator_top.sv
// Curve point evaluator. Each input transfer carries an opcode, four 2D
// points in signed Q8.8 and a parameter t in unsigned Q1.16 (65536 is one,
// larger values are treated as one); each yields exactly one output transfer
// with the point, saturated to 16 bits, and a flag that tells whether either
// coordinate was clipped. Opcode 0 is a lerp from A to B, opcode 1 a
// quadratic Bezier over A, B and C, opcode 2 a cubic Hermite point from
// P0, T0, P1 and T1, and opcode 3 returns the origin. All products round to
// nearest with halves toward plus infinity. The block takes one item in
// every cycle unless it is full and the output stalls, and holds no state
// between items. Each item passes through the eleven-stage pipeline, whose
// longest stretch is the Hermite weight chain t*t, t*t*t that must finish
// before the four weight-times-point products. A stall at the output first
// fills any empty stages, so the input keeps accepting transfers until every
// stage is full.
module curve_point_evaluator_top (
  input logic     clk,
  input logic     rst_n,
  cpe_in_if.sink  in_chan,
  cpe_out_if.source out_chan
);
  import cpe_pkg::*;

  localparam param_t T_ONE = param_t'(PARAM_ONE);
  localparam coord_t OUT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t OUT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // Per-stage occupancy and load enables. A stage loads whenever it is empty
  // or the stage after it is loading too, so bubbles collapse under a stall.
  stage_en_t v_r;
  stage_en_t en;

  // Stage 0 holds the accepted item with t already clamped to one.
  op_t       op0_r;
  coord_t    ptx_r [4];
  coord_t    pty_r [4];
  param_t    t0_r;
  param_t    t_clamp;

  herm_wts_t wts;
  lane_res_t res_x;
  lane_res_t res_y;

  // Output register: the merge of both lanes.
  coord_t    out_x_r;
  coord_t    out_y_r;
  logic      sat_flag_r;

  always_comb begin
    en[PIPE_DEPTH-1] = !v_r[PIPE_DEPTH-1] || out_chan.ready;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign t_clamp = (in_chan.curve_param > T_ONE) ? T_ONE : in_chan.curve_param;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[STG_IN]) begin
        v_r[STG_IN] <= in_chan.valid;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[STG_IN]) begin
      op0_r    <= op_t'(in_chan.opcode);
      ptx_r[0] <= in_chan.pa_x;
      ptx_r[1] <= in_chan.pb_x;
      ptx_r[2] <= in_chan.pc_x;
      ptx_r[3] <= in_chan.pd_x;
      pty_r[0] <= in_chan.pa_y;
      pty_r[1] <= in_chan.pb_y;
      pty_r[2] <= in_chan.pc_y;
      pty_r[3] <= in_chan.pd_y;
      t0_r     <= t_clamp;
    end
  end

  // The Hermite basis weights depend only on t, so one unit serves both lanes.
  cpe_basis u_basis (
    .clk (clk),
    .en  (en),
    .t   (t0_r),
    .wts (wts)
  );

  cpe_lane u_lane_x (
    .clk (clk),
    .en  (en),
    .op  (op0_r),
    .pa  (ptx_r[0]),
    .pb  (ptx_r[1]),
    .pc  (ptx_r[2]),
    .pd  (ptx_r[3]),
    .t   (t0_r),
    .wts (wts),
    .res (res_x)
  );

  cpe_lane u_lane_y (
    .clk (clk),
    .en  (en),
    .op  (op0_r),
    .pa  (pty_r[0]),
    .pb  (pty_r[1]),
    .pc  (pty_r[2]),
    .pd  (pty_r[3]),
    .t   (t0_r),
    .wts (wts),
    .res (res_y)
  );

  always_ff @(posedge clk) begin
    if (en[STG_OUT]) begin
      out_x_r    <= res_x.value;
      out_y_r    <= res_y.value;
      sat_flag_r <= res_x.clip || res_y.clip;
    end
  end

  assign in_chan.ready      = en[STG_IN];
  assign out_chan.valid     = v_r[STG_OUT];
  assign out_chan.out_x     = out_x_r;
  assign out_chan.out_y     = out_y_r;
  assign out_chan.saturated = sat_flag_r;

  // With every stage full and the output stalled, nothing may be taken in.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r) && !out_chan.ready |-> !in_chan.ready)
    else $error("input accepted while the pipeline is full and stalled");

  // A clipped result must sit at one of the range limits.
  a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.saturated |->
      (out_chan.out_x == OUT_MAX) || (out_chan.out_x == OUT_MIN) ||
      (out_chan.out_y == OUT_MAX) || (out_chan.out_y == OUT_MIN))
    else $error("saturated flag set without a clipped coordinate");

  // Occupancy grows only through an input transfer.
  a_occ_grow: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(v_r) > $past($countones(v_r)) |->
      $past(in_chan.valid && in_chan.ready))
    else $error("item appeared in the pipeline without an input transfer");

  // Occupancy shrinks only through an output transfer.
  a_occ_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(v_r) < $past($countones(v_r)) |->
      $past(out_chan.valid && out_chan.ready))
    else $error("item lost from the pipeline without an output transfer");

endmodule

// File: dv/tb_curve_point_evaluator_top.sv
module tb_curve_point_evaluator_top;
  import cpe_pkg::*;

  // The block is fed random and directed curve queries, and every output
  // transfer is checked against a point computed here from the same inputs.
  // The evaluator holds no state, so each accepted item is predicted on its
  // own and queued in arrival order.

  localparam int     RANDOM_POINTS = 500;
  localparam int     PIPE_LATENCY  = 10;
  localparam int     HOLD_CYCLES   = 80;
  localparam int     STALL_LIMIT   = 2000;
  localparam longint COORD_MAX     = (longint'(1) << (COORD_WIDTH - 1)) - 1;
  localparam longint COORD_MIN     = -COORD_MAX - 1;

  typedef struct packed {
    op_t    opcode;
    coord_t pa_x;
    coord_t pa_y;
    coord_t pb_x;
    coord_t pb_y;
    coord_t pc_x;
    coord_t pc_y;
    coord_t pd_x;
    coord_t pd_y;
    param_t curve_param;
  } curve_item_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   saturated;
  } curve_point_t;

  logic clk = 1'b0;
  logic rst_n;

  cpe_in_if  in_chan();
  cpe_out_if out_chan();

  curve_point_evaluator_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #6 clk = ~clk;

  curve_item_t  pending_items[$];
  curve_point_t expected_points[$];

  int total_items;
  int in_count;
  int out_count;
  int error_count;
  int sat_count;
  int points_by_op[4];
  int stall_cycles;

  // Set by the monitor at the rising edge when the input transfer happened,
  // read by the driver at the following falling edge.
  bit in_xfer_seen;
  // Raised for a long stretch to force the pipeline full.
  bit hold_off;

  // Sender and receiver pacing state, each owned by one process.
  int burst_left;
  int gap_left;
  int stall_mode;
  int stall_mode_left;
  int stall_phase;

  // ---------------------------------------------------------------------
  // Point prediction
  // ---------------------------------------------------------------------

  // Shift right by the fraction width, rounding to nearest with halves going
  // toward plus infinity. An arithmetic shift floors, which is what we want.
  function automatic longint round_q(longint v);
    return (v + longint'(RND_HALF)) >>> PARAM_FRAC_BITS;
  endfunction

  function automatic longint lerp_q(longint a, longint b, longint t);
    return a + round_q((b - a) * t);
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    if (v < COORD_MIN) return coord_t'(COORD_MIN);
    return coord_t'(v);
  endfunction

  // One coordinate lane of the curve; a, b, c, d are the four points' values
  // on this axis and t is already clamped to one.
  function automatic longint curve_lane(op_t op, longint a, longint b, longint c,
                                        longint d, longint t);
    longint tsq, tcub, h00, h01, h10, h11;
    case (op)
      OP_LERP:   return lerp_q(a, b, t);
      // Bezier: both midpoints are rounded back to Q8.8 before the last lerp.
      OP_BEZIER: return lerp_q(lerp_q(a, b, t), lerp_q(b, c, t), t);
      default: begin
        // Hermite basis with t squared and cubed each rounded to Q1.16.
        tsq  = round_q(t * t);
        tcub = round_q(tsq * t);
        h00  = 2 * tcub - 3 * tsq + longint'(PARAM_ONE);
        h01  = -2 * tcub + 3 * tsq;
        h10  = tcub - 2 * tsq + t;
        h11  = tcub - tsq;
        return round_q(h00 * a + h10 * b + h01 * c + h11 * d);
      end
    endcase
  endfunction

  function automatic curve_point_t predict_point(curve_item_t it);
    curve_point_t res;
    longint       t, vx, vy;
    res = '0;
    // Parameters above one behave as exactly one.
    t = (it.curve_param > PARAM_ONE) ? longint'(PARAM_ONE) : longint'(it.curve_param);
    // The unused opcode always answers with the origin and no clipping.
    if (it.opcode != OP_NONE) begin
      vx = curve_lane(it.opcode, it.pa_x, it.pb_x, it.pc_x, it.pd_x, t);
      vy = curve_lane(it.opcode, it.pa_y, it.pb_y, it.pc_y, it.pd_y, t);
      res.x = clamp_coord(vx);
      res.y = clamp_coord(vy);
      res.saturated = (longint'(res.x) != vx) || (longint'(res.y) != vy);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  task automatic queue_point(op_t op, int ax, int ay, int bx, int by, int cx, int cy,
                             int dx, int dy, int t);
    curve_item_t it;
    it.opcode      = op;
    it.pa_x        = coord_t'(ax);
    it.pa_y        = coord_t'(ay);
    it.pb_x        = coord_t'(bx);
    it.pb_y        = coord_t'(by);
    it.pc_x        = coord_t'(cx);
    it.pc_y        = coord_t'(cy);
    it.pd_x        = coord_t'(dx);
    it.pd_y        = coord_t'(dy);
    it.curve_param = param_t'(t);
    pending_items.push_back(it);
  endtask

  // Coordinates are mostly full range, with a share of small values so that
  // Hermite points do not nearly always clip, and a share of extremes.
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return coord_t'(COORD_MAX);
          1:       return coord_t'(COORD_MIN);
          2:       return coord_t'(0);
          3:       return coord_t'(-1);
          default: return coord_t'(1);
        endcase
      end
      1, 2:    return coord_t'(int'($urandom_range(0, 2047)) - 1024);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // The parameter is usually within [0, 1], sometimes at a corner and
  // sometimes anywhere in its 17 bits so that clamping is exercised.
  function automatic param_t rand_param();
    case ($urandom_range(0, 9))
      0: return param_t'($urandom);
      1: begin
        case ($urandom_range(0, 5))
          0:       return param_t'(0);
          1:       return param_t'(1);
          2:       return param_t'(PARAM_ONE - 1);
          3:       return param_t'(PARAM_ONE);
          4:       return param_t'(RND_HALF);
          default: return param_t'(PARAM_ONE + 1);
        endcase
      end
      default: return param_t'($urandom_range(0, PARAM_ONE));
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus: directed corners first, then random queries
  // ---------------------------------------------------------------------
  initial begin
    curve_item_t it;
    int          r;

    // Lerp at both ends, at the midpoint, just below one and just above zero,
    // with the unused points loaded to show they do not leak into the result.
    queue_point(OP_LERP, 100, -200, 3000, -4000, 0, 0, 0, 0, 0);
    queue_point(OP_LERP, 100, -200, 3000, -4000, 555, -555, 777, -777, PARAM_ONE);
    queue_point(OP_LERP, -32768, 32767, 32767, -32768, 0, 0, 0, 0, RND_HALF);
    queue_point(OP_LERP, 32767, -32768, -32768, 32767, -32768, 32767, 32767, -32768,
                PARAM_ONE - 1);
    queue_point(OP_LERP, 0, 0, 32767, -32768, 0, 0, 0, 0, 1);
    // Exact halves in the product must round upward in both signs.
    queue_point(OP_LERP, 0, 0, 1, -1, 0, 0, 0, 0, RND_HALF);
    // Parameters above one are clamped.
    queue_point(OP_LERP, 1, 2, -5, 7, 0, 0, 0, 0, 131071);
    queue_point(OP_LERP, -32768, -32768, 32767, 32767, 0, 0, 0, 0, PARAM_ONE + 1);

    // Quadratic Bezier at both ends, the middle and with clamping; the fourth
    // point is loaded and must be ignored.
    queue_point(OP_BEZIER, 256, -256, 32767, -32768, -512, 512, 1234, -1234, 0);
    queue_point(OP_BEZIER, 256, -256, 32767, -32768, -512, 512, 1234, -1234, PARAM_ONE);
    queue_point(OP_BEZIER, -32768, 32767, 32767, -32768, -32768, 32767, 0, 0, RND_HALF);
    queue_point(OP_BEZIER, 10, 20, 30, 40, 50, 60, 32767, -32768, 98304);

    // Hermite at both ends, with large tangents to clip in either direction,
    // with clamping, and with all coordinates at the upper extreme.
    queue_point(OP_HERMITE, 1000, -1000, 200, 300, -700, 900, -50, 40, 0);
    queue_point(OP_HERMITE, 1000, -1000, 200, 300, -700, 900, -50, 40, PARAM_ONE);
    queue_point(OP_HERMITE, 32767, 32767, 32767, 32767, 32767, 32767, -32768, -32768,
                RND_HALF);
    queue_point(OP_HERMITE, -32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767,
                21845);
    queue_point(OP_HERMITE, 512, 512, -256, 256, 768, -768, 128, -128, PARAM_ONE + 1);
    queue_point(OP_HERMITE, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 40000);

    // The unused opcode answers with the origin whatever the payload.
    queue_point(OP_NONE, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768,
                131071);
    queue_point(OP_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    repeat (RANDOM_POINTS) begin
      r = $urandom_range(0, 19);
      it.opcode      = (r == 0) ? OP_NONE : op_t'(r % 3);
      it.pa_x        = rand_coord();
      it.pa_y        = rand_coord();
      it.pb_x        = rand_coord();
      it.pb_y        = rand_coord();
      it.pc_x        = rand_coord();
      it.pc_y        = rand_coord();
      it.pd_x        = rand_coord();
      it.pd_y        = rand_coord();
      it.curve_param = rand_param();
      pending_items.push_back(it);
    end
    total_items = pending_items.size();
  end

  // ---------------------------------------------------------------------
  // Reset and known start values
  // ---------------------------------------------------------------------
  initial begin
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.opcode      = OP_LERP;
    in_chan.pa_x        = '0;
    in_chan.pa_y        = '0;
    in_chan.pb_x        = '0;
    in_chan.pb_y        = '0;
    in_chan.pc_x        = '0;
    in_chan.pc_y        = '0;
    in_chan.pd_x        = '0;
    in_chan.pd_y        = '0;
    in_chan.curve_param = '0;
    out_chan.ready      = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------
  // Driver: offers queued items in bursts separated by random gaps. An item
  // stays on the bus until the transfer is seen at a rising edge.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    curve_item_t nxt;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      burst_left = $urandom_range(1, 16);
      gap_left   = 0;
    end else if (!in_chan.valid || in_xfer_seen) begin
      // While the receiver is held off, gaps are skipped so the sender keeps
      // pushing and the pipeline fills.
      if (gap_left > 0 && !hold_off) begin
        gap_left--;
        in_chan.valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        nxt = pending_items.pop_front();
        in_chan.opcode      <= nxt.opcode;
        in_chan.pa_x        <= nxt.pa_x;
        in_chan.pa_y        <= nxt.pa_y;
        in_chan.pb_x        <= nxt.pb_x;
        in_chan.pb_y        <= nxt.pb_y;
        in_chan.pc_x        <= nxt.pc_x;
        in_chan.pc_y        <= nxt.pc_y;
        in_chan.pd_x        <= nxt.pd_x;
        in_chan.pd_y        <= nxt.pd_y;
        in_chan.curve_param <= nxt.curve_param;
        in_chan.valid       <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // A zero gap joins two bursts into one long back-to-back stretch.
          burst_left = $urandom_range(1, 40);
          case ($urandom_range(0, 3))
            0:       gap_left = 0;
            1, 2:    gap_left = $urandom_range(1, 3);
            default: gap_left = $urandom_range(4, 15);
          endcase
        end
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: ready follows a pattern that is redrawn at random, one of these:
  // always ready, coin flips, a short periodic stall, or mostly stalled.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    logic rdy;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_mode_left = 0;
    end else begin
      if (stall_mode_left == 0) begin
        stall_mode      = $urandom_range(0, 3);
        stall_mode_left = $urandom_range(16, 96);
        stall_phase     = 0;
      end
      stall_mode_left--;
      stall_phase++;
      case (stall_mode)
        0:       rdy = 1'b1;
        1:       rdy = 1'($urandom_range(0, 1));
        2:       rdy = (stall_phase % 4) != 0;
        default: rdy = (stall_phase % 16) < 3;
      endcase
      out_chan.ready <= rdy && !hold_off;
    end
  end

  // Once the run is under way the receiver refuses everything for a long
  // stretch, which must back the pipeline up until the input stalls.
  initial begin
    hold_off = 1'b0;
    wait (in_count >= 200);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Monitor: predicts on each input transfer and checks each output
  // transfer against the oldest pending prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    curve_item_t  seen;
    curve_point_t want;
    in_xfer_seen = 1'b0;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        out_count++;
        if (expected_points.size() == 0) begin
          $error("output transfer with no point pending: x=%0d y=%0d saturated=%0b",
                 out_chan.out_x, out_chan.out_y, out_chan.saturated);
          error_count++;
        end else begin
          want = expected_points.pop_front();
          if (out_chan.out_x !== want.x) begin
            $error("out_x mismatch: expected %0d, got %0d", want.x, out_chan.out_x);
            error_count++;
          end
          if (out_chan.out_y !== want.y) begin
            $error("out_y mismatch: expected %0d, got %0d", want.y, out_chan.out_y);
            error_count++;
          end
          if (out_chan.saturated !== want.saturated) begin
            $error("saturated mismatch: expected %0b, got %0b",
                   want.saturated, out_chan.saturated);
            error_count++;
          end
          if (want.saturated) sat_count++;
        end
      end

      if (in_chan.valid && in_chan.ready) begin
        seen.opcode      = op_t'(in_chan.opcode);
        seen.pa_x        = in_chan.pa_x;
        seen.pa_y        = in_chan.pa_y;
        seen.pb_x        = in_chan.pb_x;
        seen.pb_y        = in_chan.pb_y;
        seen.pc_x        = in_chan.pc_x;
        seen.pc_y        = in_chan.pc_y;
        seen.pd_x        = in_chan.pd_x;
        seen.pd_y        = in_chan.pd_y;
        seen.curve_param = in_chan.curve_param;
        expected_points.push_back(predict_point(seen));
        points_by_op[seen.opcode]++;
        in_count++;
        in_xfer_seen = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: too many cycles without any transfer ends the run.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("no transfer for %0d cycles: %0d of %0d items in, %0d points pending",
                 STALL_LIMIT, in_count, total_items, expected_points.size());
        $display("[curve_point_evaluator_top] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // End of run: drain, give stray outputs a chance to show up, then report.
  // ---------------------------------------------------------------------
  initial begin
    wait (rst_n === 1'b1);
    wait (total_items > 0 && in_count == total_items);
    wait (expected_points.size() == 0);
    repeat (2 * PIPE_LATENCY + 4) @(posedge clk);
    if (expected_points.size() != 0) begin
      $error("%0d predicted points never came out", expected_points.size());
      error_count++;
    end
    $display("Checked %0d points: %0d lerp, %0d Bezier, %0d Hermite, %0d unused opcode.",
             out_count, points_by_op[OP_LERP], points_by_op[OP_BEZIER],
             points_by_op[OP_HERMITE], points_by_op[OP_NONE]);
    $display("%0d points clipped; output held off for %0d cycles to fill the pipeline.",
             sat_count, HOLD_CYCLES);
    if (error_count == 0) begin
      $display("[curve_point_evaluator_top] OK");
    end else begin
      $display("[curve_point_evaluator_top] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/cpe_pkg.sv
rtl/cpe_in_if.sv
rtl/cpe_out_if.sv
rtl/cpe_basis.sv
rtl/cpe_lane.sv
rtl/curve_point_evaluator_top.sv
dv/tb_curve_point_evaluator_top.sv
